FILE: hdl/mte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants for the multiset table engine: field widths,
// parameter defaults, operation codes and the memory command bundle.
// ----------------------------------------------------------------------------
package mte_pkg;

  // Default sizing of the element store.
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the word fields on the channels.
  localparam int OPCODE_W   = 2;
  localparam int IN_VALUE_W = 32;
  localparam int TALLY_W    = 7;

  // Operation codes carried in the opcode field.
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_COUNT  = 2'd3
  } opcode_t;

  // Strobes from the sequencer to the element store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage : mte_pkg
`default_nettype wire

FILE: hdl/mte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_in_if / mte_out_if
// Valid/ready channels of the multiset table engine: the request word and
// the result word.
// ----------------------------------------------------------------------------
interface mte_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [mte_pkg::OPCODE_W-1:0]             opcode;
  logic signed [mte_pkg::IN_VALUE_W-1:0]    value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface : mte_in_if

interface mte_out_if;
  logic                            valid;
  logic                            ready;
  logic                            success;
  logic [mte_pkg::TALLY_W-1:0]     occurrences;
  logic [mte_pkg::TALLY_W-1:0]     entries_held;
  logic                            is_empty;
  logic                            full_error;

  modport source (output valid, output success, output occurrences,
                  output entries_held, output is_empty, output full_error,
                  input ready);
  modport sink   (input valid, input success, input occurrences,
                  input entries_held, input is_empty, input full_error,
                  output ready);
endinterface : mte_out_if
`default_nettype wire

FILE: hdl/mte_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_store
// Single-port-write, single-port-read synchronous element memory with a
// registered read. Contents are undefined until written.
// ----------------------------------------------------------------------------
module mte_store #(
  parameter int DEPTH = mte_pkg::CAPACITY_DEF,
  parameter int AW    = 6,
  parameter int DW    = mte_pkg::VALUE_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire mte_pkg::mem_cmd_t cmd,
  input  wire logic [AW-1:0]     rd_addr,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DW-1:0]     wr_data,
  output logic [DW-1:0]          rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : mte_store
`default_nettype wire

FILE: hdl/multiset_table_engine.sv
// Sequence: add writes at acceptance and then loads the result word; search,
// count and remove scan the held entries in order, and on a hit remove then
// moves the last entry into the hole (search and remove stop at the first match).
// Throughput: a new word is taken only once the last result word is loaded;
// the element memory read port, scanned one entry per cycle, sets the pace.
// Reset: synchronous, active low; the bag comes up empty, memory is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// multiset_table_engine
// Bounded multiset of signed values held compactly in one memory. A sequencer
// scans the memory for remove, search and count, appends on add, and fills
// the hole left by a remove with the last entry.
// ----------------------------------------------------------------------------
module multiset_table_engine #(
  parameter int CAPACITY    = mte_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = mte_pkg::VALUE_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  mte_in_if.sink     in_ch,
  mte_out_if.source  out_ch
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REM_LAST,
    S_REM_WR,
    S_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  mte_pkg::opcode_t            op_r, op_nxt;
  logic [VALUE_WIDTH-1:0]      val_r, val_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            iss_r, iss_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pend_idx_r, pend_idx_nxt;
  logic                        hit_r, hit_nxt;
  logic [AW-1:0]               hit_idx_r, hit_idx_nxt;
  logic [CNT_W-1:0]            occ_r, occ_nxt;
  logic                        full_r, full_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_success_r, out_success_nxt;
  logic [mte_pkg::TALLY_W-1:0] out_occ_r, out_occ_nxt;
  logic [mte_pkg::TALLY_W-1:0] out_held_r, out_held_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic                        out_full_r, out_full_nxt;

  mte_pkg::mem_cmd_t           mem_cmd;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0]      wr_data, rd_data;

  logic signed [63:0]          in_val64;
  logic [VALUE_WIDTH-1:0]      in_val;
  logic                        in_fire;
  logic                        match;
  logic                        out_free;

  // Values are compared on the low bits of the sign-extended request value.
  assign in_val64 = 64'(in_ch.value);
  assign in_val   = in_val64[VALUE_WIDTH-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign match       = pend_r && (rd_data == val_r);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.success      = out_success_r;
  assign out_ch.occurrences  = out_occ_r;
  assign out_ch.entries_held = out_held_r;
  assign out_ch.is_empty     = out_empty_r;
  assign out_ch.full_error   = out_full_r;

  // Element memory. The sequencer never reads and writes in the same cycle,
  // so no forwarding path is needed.
  mte_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Sequencer next-state and memory command logic.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    count_nxt    = count_r;
    iss_nxt      = iss_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    occ_nxt      = occ_r;
    full_nxt     = full_r;

    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_success_nxt = out_success_r;
    out_occ_nxt     = out_occ_r;
    out_held_nxt    = out_held_r;
    out_empty_nxt   = out_empty_r;
    out_full_nxt    = out_full_r;

    mem_cmd = '0;
    rd_addr = iss_r[AW-1:0];
    wr_addr = count_r[AW-1:0];
    wr_data = in_val;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = mte_pkg::opcode_t'(in_ch.opcode);
          val_nxt  = in_val;
          iss_nxt  = '0;
          hit_nxt  = 1'b0;
          occ_nxt  = '0;
          full_nxt = 1'b0;
          if (mte_pkg::opcode_t'(in_ch.opcode) == mte_pkg::OP_ADD) begin
            // Append at the end of the compact store, or reject when full.
            if (count_r < CAP_C) begin
              mem_cmd.wr_en = 1'b1;
              count_nxt     = count_r + ONE_C;
              hit_nxt       = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Compare the entry read last cycle while issuing the next read.
        if (match) begin
          occ_nxt = occ_r + ONE_C;
        end
        if (match && (op_r != mte_pkg::OP_COUNT)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pend_idx_r;
          state_nxt   = (op_r == mte_pkg::OP_REMOVE) ? S_REM_LAST : S_FIN;
        end else if (iss_r < count_r) begin
          mem_cmd.rd_en = 1'b1;
          pend_nxt      = 1'b1;
          pend_idx_nxt  = iss_r[AW-1:0];
          iss_nxt       = iss_r + ONE_C;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_REM_LAST: begin
        // Fetch the last entry to fill the hole.
        mem_cmd.rd_en = 1'b1;
        rd_addr       = AW'(count_r - ONE_C);
        state_nxt     = S_REM_WR;
      end

      S_REM_WR: begin
        mem_cmd.wr_en = 1'b1;
        wr_addr       = hit_idx_r;
        wr_data       = rd_data;
        count_nxt     = count_r - ONE_C;
        state_nxt     = S_FIN;
      end

      S_FIN: begin
        // Load the result word once the output register is free.
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = hit_r;
          out_occ_nxt     = (op_r == mte_pkg::OP_COUNT) ?
                            mte_pkg::TALLY_W'(occ_r) : '0;
          out_held_nxt    = mte_pkg::TALLY_W'(count_r);
          out_empty_nxt   = (count_r == '0);
          out_full_nxt    = full_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    val_r         <= val_nxt;
    iss_r         <= iss_nxt;
    pend_idx_r    <= pend_idx_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    occ_r         <= occ_nxt;
    full_r        <= full_nxt;
    out_success_r <= out_success_nxt;
    out_occ_r     <= out_occ_nxt;
    out_held_r    <= out_held_nxt;
    out_empty_r   <= out_empty_nxt;
    out_full_r    <= out_full_nxt;
  end

endmodule : multiset_table_engine
`default_nettype wire

FILE: hdl/mte_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mte_chk
// Port-level checks for the multiset table engine, bound to the top level.
// ----------------------------------------------------------------------------
module mte_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire                              out_success,
  input wire [mte_pkg::TALLY_W-1:0]       out_occurrences,
  input wire [mte_pkg::TALLY_W-1:0]       out_entries_held,
  input wire                              out_is_empty,
  input wire                              out_full_error
);

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_success) &&
      $stable(out_occurrences) && $stable(out_entries_held) &&
      $stable(out_is_empty) && $stable(out_full_error))
    else $error("result word changed while stalled");

  // A rejected add stores nothing and reports no success or tally.
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_error |-> !out_success && (out_occurrences == '0))
    else $error("full error together with success or tally");

  // A nonzero tally only comes from a count, which never reports success.
  a_occ_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_occurrences != '0) |-> !out_success)
    else $error("tally together with success");

  // An empty bag holds no entries.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_entries_held == '0))
    else $error("empty flag with nonzero size");

  // No result word appears right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule : mte_chk

bind multiset_table_engine mte_chk u_mte_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_success      (out_ch.success),
  .out_occurrences  (out_ch.occurrences),
  .out_entries_held (out_ch.entries_held),
  .out_is_empty     (out_ch.is_empty),
  .out_full_error   (out_ch.full_error)
);
`default_nettype wire
